/* hw/rtl/rsi_pkg.sv */
// Shared types and constants of the ray/sphere intersection block.
// No dependencies; rsi_mul and ray_sphere_intersect import this package.
package rsi_pkg;

    localparam int CRD_W = 32;       // one Q-format coordinate
    localparam int RAD_W = 31;       // sphere radius
    localparam int CFG_W = 32;       // configuration write data
    localparam int A_W = 64;         // d.d stays below 2^64
    localparam int QB = 35;          // quotient bits kept before saturation
    localparam int MUL_DIGIT = 8;    // multiplier bits consumed per cell

    localparam logic signed [CRD_W-1:0] CRD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [CRD_W-1:0] CRD_MIN = 32'sh8000_0000;

    typedef enum logic [1:0] {
        CFG_CENTER_X = 2'd0,
        CFG_CENTER_Y = 2'd1,
        CFG_CENTER_Z = 2'd2,
        CFG_RADIUS   = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [CRD_W-1:0] origin_x;
        logic [CRD_W-1:0] origin_y;
        logic [CRD_W-1:0] origin_z;
        logic [CRD_W-1:0] dir_x;
        logic [CRD_W-1:0] dir_y;
        logic [CRD_W-1:0] dir_z;
    } ray_t;

    typedef struct packed {
        logic             hit;
        logic [CRD_W-1:0] point_x;
        logic [CRD_W-1:0] point_y;
        logic [CRD_W-1:0] point_z;
    } point_t;

    // number of cells in a multiplier chain for a multiplier operand of wb bits
    function automatic int mul_cells(input int wb);
        return (wb + MUL_DIGIT - 1) / MUL_DIGIT;
    endfunction

endpackage

/* hw/rtl/rsi_if.sv */
// Valid/ready stream channel carrying one word of type T.
// Depends on nothing; the payload type is given where the channel is declared.
interface rsi_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/rsi_dly.sv */
// Enabled delay line that carries side data alongside the arithmetic chains.
// No package dependencies.
module rsi_dly #(
    parameter int W = 1,
    parameter int N = 1
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);
    logic [W-1:0] pipe_reg [N];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < N; k++)
            begin
                pipe_reg[k] <= '0;
            end
        end
        else if (en)
        begin
            pipe_reg[0] <= d;
            for (int k = 1; k < N; k++)
            begin
                pipe_reg[k] <= pipe_reg[k-1];
            end
        end
    end

    assign q = pipe_reg[N-1];
endmodule

/* hw/rtl/rsi_mul.sv */
// Signed multiplier as a chain of cells, each adding one 8-bit digit of b times a.
// Uses rsi_pkg for the digit size.
module rsi_mul #(
    parameter int WA = 33,
    parameter int WB = 33
) (
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [WA-1:0]    a,
    input  logic signed [WB-1:0]    b,
    output logic signed [WA+WB-1:0] p
);
    import rsi_pkg::*;

    localparam int NC = mul_cells(WB);
    localparam int WBP = NC * MUL_DIGIT;
    localparam int WP = WA + WB;

    logic signed [WA-1:0]  a_reg [NC];
    logic signed [WBP-1:0] b_reg [NC];
    logic signed [WP-1:0]  acc_reg [NC];

    for (genvar k = 0; k < NC; k++)
    begin : g_cell
        logic signed [WA-1:0]          a_in;
        logic signed [WBP-1:0]         b_in;
        logic signed [WP-1:0]          acc_in;
        logic signed [MUL_DIGIT:0]     dig;
        logic signed [WA+MUL_DIGIT:0]  pp;
        logic signed [WP-1:0]          acc_next;

        if (k == 0)
        begin : g_head
            assign a_in = a;
            assign b_in = WBP'(b);
            assign acc_in = '0;
        end
        else
        begin : g_body
            assign a_in = a_reg[k-1];
            assign b_in = b_reg[k-1];
            assign acc_in = acc_reg[k-1];
        end

        // top digit carries the sign, lower digits are unsigned
        if (k == NC - 1)
        begin : g_top
            assign dig = $signed({b_in[MUL_DIGIT*k+MUL_DIGIT-1],
                                  b_in[MUL_DIGIT*k +: MUL_DIGIT]});
        end
        else
        begin : g_low
            assign dig = $signed({1'b0, b_in[MUL_DIGIT*k +: MUL_DIGIT]});
        end

        assign pp = a_in * dig;
        assign acc_next = acc_in + (WP'(pp) <<< (MUL_DIGIT * k));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                acc_reg[k] <= acc_next;
            end
        end

        if (k < NC - 1)
        begin : g_pass
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    a_reg[k] <= a_in;
                    b_reg[k] <= b_in;
                end
            end
        end
    end

    assign p = acc_reg[NC-1];
endmodule

/* hw/rtl/rsi_sqrt.sv */
// Floor square root as a chain of cells, one result bit per cell, MSB first.
// No package dependencies.
module rsi_sqrt #(
    parameter int WX = 158
) (
    input  logic                   clk,
    input  logic                   en,
    input  logic [WX-1:0]          x,
    output logic [(WX+1)/2-1:0]    root
);
    localparam int WS = (WX + 1) / 2;
    localparam int WT = WX + 2;

    logic [WX-1:0] rem_reg [WS];
    logic [WS-1:0] res_reg [WS];

    for (genvar j = 0; j < WS; j++)
    begin : g_cell
        localparam int I = WS - 1 - j;

        logic [WX-1:0] rem_in;
        logic [WS-1:0] res_in;
        logic [WT-1:0] trial;
        logic          take;
        logic [WX-1:0] rem_next;
        logic [WS-1:0] res_next;

        if (j == 0)
        begin : g_head
            assign rem_in = x;
            assign res_in = '0;
        end
        else
        begin : g_body
            assign rem_in = rem_reg[j-1];
            assign res_in = res_reg[j-1];
        end

        // trial = (2*res + 2^I) * 2^I with res holding only bits above I
        assign trial = (WT'(res_in) << (I + 1)) + (WT'(1) << (2 * I));
        assign take = WT'(rem_in) >= trial;
        assign rem_next = take ? WX'(WT'(rem_in) - trial) : rem_in;
        assign res_next = take ? (res_in | (WS'(1) << I)) : res_in;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                res_reg[j] <= res_next;
            end
        end

        if (j < WS - 1)
        begin : g_pass
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[j] <= rem_next;
                end
            end
        end
    end

    assign root = res_reg[WS-1];
endmodule

/* hw/rtl/rsi_div.sv */
// Restoring divider as a chain of cells, one quotient bit per cell, MSB first.
// No package dependencies; the caller guarantees num < den * 2^QB.
module rsi_div #(
    parameter int WD = 80,
    parameter int QB = 35
) (
    input  logic             clk,
    input  logic             en,
    input  logic [WD+QB-1:0] num,
    input  logic [WD-1:0]    den,
    output logic [QB-1:0]    quo,
    output logic             rem_nz
);
    localparam int WR = WD + QB;

    logic [WR-1:0] rem_reg [QB];
    logic [QB-1:0] quo_reg [QB];
    logic [WD-1:0] den_reg [QB];

    for (genvar j = 0; j < QB; j++)
    begin : g_cell
        localparam int I = QB - 1 - j;

        logic [WR-1:0] rem_in;
        logic [QB-1:0] quo_in;
        logic [WD-1:0] den_in;
        logic [WR-1:0] trial;
        logic          take;
        logic [WR-1:0] rem_next;
        logic [QB-1:0] quo_next;

        if (j == 0)
        begin : g_head
            assign rem_in = num;
            assign quo_in = '0;
            assign den_in = den;
        end
        else
        begin : g_body
            assign rem_in = rem_reg[j-1];
            assign quo_in = quo_reg[j-1];
            assign den_in = den_reg[j-1];
        end

        assign trial = WR'(den_in) << I;
        assign take = rem_in >= trial;
        assign rem_next = take ? rem_in - trial : rem_in;
        assign quo_next = take ? (quo_in | (QB'(1) << I)) : quo_in;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j] <= rem_next;
                quo_reg[j] <= quo_next;
            end
        end

        if (j < QB - 1)
        begin : g_pass
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    den_reg[j] <= den_in;
                end
            end
        end
    end

    assign quo = quo_reg[QB-1];
    assign rem_nz = rem_reg[QB-1] != '0;
endmodule

/* hw/rtl/ray_sphere_intersect.sv */
// Ray against sphere intersection: one ray word in, one point word out.
// Depends on rsi_pkg, rsi_if, rsi_dly, rsi_mul, rsi_sqrt and rsi_div.
//
// Usage:
//   rays   (sink)   : origin and direction in signed fixed point, FRAC_BITS fraction bits.
//   points (source) : hit flag and the chosen intersection point, saturated to
//                     32 bits; all zero when there is no hit or the direction is zero.
//   cfg_we/cfg_index/cfg_data : sphere center x/y/z and radius, written while idle.
// Every ray produces exactly one point word, in order.
// Throughput: one ray per cycle while the receiver takes the point words, fully pipelined.
// Most of the pipeline depth lies in the square root chain (63 + FRAC_BITS cells)
//   and the three parallel divider chains (35 cells each).
// The whole pipeline advances on one enable: when the receiver stalls with a word
//   held in the output register, every stage holds and rays.ready drops.
// Reset clears all valid bits and loads center 0 and radius 1.0; rays.ready is high
//   as soon as reset is released, since the output register starts empty.
module ray_sphere_intersect #(
    parameter int FRAC_BITS = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  rsi_pkg::cfg_index_t       cfg_index,
    input  logic [rsi_pkg::CFG_W-1:0] cfg_data,
    rsi_if.sink                       rays,
    rsi_if.source                     points
);
    import rsi_pkg::*;

    localparam int WOC = CRD_W + 1;                  // o - c
    localparam int WP1 = 2 * WOC;                    // first product
    localparam int WQ1 = 69;                         // a, b, cq
    localparam int WP2 = 2 * WQ1;                    // second product
    localparam int QMAG_W = 126;                     // discriminant bound when >= 0
    localparam int WX = QMAG_W + 2 * FRAC_BITS;
    localparam int WS = (WX + 1) / 2;
    localparam int WN = WQ1 + FRAC_BITS + 1;         // numerator of t
    localparam int WM = WN + CRD_W;                  // d * n
    localparam int WDEN = A_W + FRAC_BITS;
    localparam int WR = WDEN + QB;
    localparam int WO = QB + 3;                      // o + step
    localparam int LA = mul_cells(WOC);
    localparam int LB = mul_cells(WQ1);
    localparam int LC = mul_cells(CRD_W);

    typedef struct packed {
        logic                  v;
        logic [2:0][CRD_W-1:0] o;
        logic [2:0][CRD_W-1:0] d;
    } sb_a_t;

    typedef struct packed {
        logic                  v;
        logic                  a_zero;
        logic                  cq_neg;
        logic [2:0][CRD_W-1:0] o;
        logic [2:0][CRD_W-1:0] d;
        logic [A_W-1:0]        a;
        logic [WQ1-1:0]        b;
    } sb_b_t;

    typedef struct packed {
        logic                  v;
        logic                  hit;
        logic                  near;
        logic [2:0][CRD_W-1:0] o;
        logic [2:0][CRD_W-1:0] d;
        logic [A_W-1:0]        a;
        logic [WQ1-1:0]        b;
    } sb_s_t;

    typedef struct packed {
        logic                  v;
        logic                  hit;
        logic [2:0][CRD_W-1:0] o;
        logic [A_W-1:0]        a;
    } sb_c_t;

    typedef struct packed {
        logic                  v;
        logic                  hit;
        logic [2:0]            neg;
        logic [2:0]            ovf;
        logic [2:0][CRD_W-1:0] o;
    } sb_d_t;

    // configuration
    logic signed [CRD_W-1:0] ctr_reg [3];
    logic [RAD_W-1:0]        rad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctr_reg[0] <= '0;
            ctr_reg[1] <= '0;
            ctr_reg[2] <= '0;
            rad_reg <= RAD_W'(1) << FRAC_BITS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CENTER_X: ctr_reg[0] <= cfg_data;
                CFG_CENTER_Y: ctr_reg[1] <= cfg_data;
                CFG_CENTER_Z: ctr_reg[2] <= cfg_data;
                CFG_RADIUS:   rad_reg <= cfg_data[RAD_W-1:0];
                default:      ;
            endcase
        end
    end

    // global advance: hold everything while the output word waits
    logic   en;
    logic   out_valid_reg;
    point_t point_reg;

    assign en = !out_valid_reg || points.ready;
    assign rays.ready = en;

    // stage 0: register ray, form o - c
    sb_a_t                 s0_reg;
    sb_a_t                 s0_next;
    logic signed [WOC-1:0] oc0_reg [3];
    logic signed [WOC-1:0] oc0_next [3];

    always_comb
    begin
        s0_next.v = rays.valid;
        s0_next.o[0] = rays.data.origin_x;
        s0_next.o[1] = rays.data.origin_y;
        s0_next.o[2] = rays.data.origin_z;
        s0_next.d[0] = rays.data.dir_x;
        s0_next.d[1] = rays.data.dir_y;
        s0_next.d[2] = rays.data.dir_z;
        for (int i = 0; i < 3; i++)
        begin
            oc0_next[i] = WOC'($signed(s0_next.o[i])) - WOC'(ctr_reg[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_reg <= '0;
        end
        else if (en)
        begin
            s0_reg <= s0_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            oc0_reg <= oc0_next;
        end
    end

    // phase A: d.d, oc.d, oc.oc and r*r
    logic signed [WP1-1:0] dd [3];
    logic signed [WP1-1:0] od [3];
    logic signed [WP1-1:0] oo [3];
    logic signed [WP1-1:0] rr;
    sb_a_t                 sa;

    for (genvar i = 0; i < 3; i++)
    begin : g_pa
        rsi_mul #(.WA(WOC), .WB(WOC)) u_dd (
            .clk (clk), .en (en),
            .a   (WOC'($signed(s0_reg.d[i]))), .b (WOC'($signed(s0_reg.d[i]))),
            .p   (dd[i])
        );
        rsi_mul #(.WA(WOC), .WB(WOC)) u_od (
            .clk (clk), .en (en),
            .a   (oc0_reg[i]), .b (WOC'($signed(s0_reg.d[i]))),
            .p   (od[i])
        );
        rsi_mul #(.WA(WOC), .WB(WOC)) u_oo (
            .clk (clk), .en (en),
            .a   (oc0_reg[i]), .b (oc0_reg[i]),
            .p   (oo[i])
        );
    end

    rsi_mul #(.WA(WOC), .WB(WOC)) u_rr (
        .clk (clk), .en (en),
        .a   ($signed({2'b00, rad_reg})), .b ($signed({2'b00, rad_reg})),
        .p   (rr)
    );

    rsi_dly #(.W($bits(sb_a_t)), .N(LA)) u_dly_a (
        .clk (clk), .rst_n (rst_n), .en (en), .d (s0_reg), .q (sa)
    );

    // stage 1: sums
    sb_b_t                 s1_reg;
    sb_b_t                 s1_next;
    logic signed [WQ1-1:0] cq1_reg;
    logic signed [WQ1-1:0] a_sum;
    logic signed [WQ1-1:0] b_sum;
    logic signed [WQ1-1:0] cq_sum;

    always_comb
    begin
        a_sum = WQ1'(dd[0]) + WQ1'(dd[1]) + WQ1'(dd[2]);
        b_sum = WQ1'(od[0]) + WQ1'(od[1]) + WQ1'(od[2]);
        cq_sum = WQ1'(oo[0]) + WQ1'(oo[1]) + WQ1'(oo[2]) - WQ1'(rr);
        s1_next.v = sa.v;
        s1_next.o = sa.o;
        s1_next.d = sa.d;
        s1_next.a = a_sum[A_W-1:0];
        s1_next.a_zero = a_sum == '0;
        s1_next.b = b_sum;
        s1_next.cq_neg = cq_sum[WQ1-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
        end
        else if (en)
        begin
            s1_reg <= s1_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cq1_reg <= cq_sum;
        end
    end

    // phase B: b*b and a*cq
    logic signed [WP2-1:0] bb;
    logic signed [WP2-1:0] acq;
    sb_b_t                 sb;

    rsi_mul #(.WA(WQ1), .WB(WQ1)) u_bb (
        .clk (clk), .en (en), .a ($signed(s1_reg.b)), .b ($signed(s1_reg.b)), .p (bb)
    );
    rsi_mul #(.WA(WQ1), .WB(WQ1)) u_acq (
        .clk (clk), .en (en), .a ($signed(WQ1'(s1_reg.a))), .b (cq1_reg), .p (acq)
    );
    rsi_dly #(.W($bits(sb_b_t)), .N(LB)) u_dly_b (
        .clk (clk), .rst_n (rst_n), .en (en), .d (s1_reg), .q (sb)
    );

    // stage 2: discriminant, hit and root choice
    sb_s_t              s2_reg;
    sb_s_t              s2_next;
    logic [QMAG_W-1:0]  qm2_reg;
    logic signed [WP2:0] disc;

    always_comb
    begin
        disc = (WP2+1)'(bb) - (WP2+1)'(acq);
        s2_next.v = sb.v;
        s2_next.hit = !sb.a_zero && !disc[WP2];
        // near root only when it lies ahead: b < 0 and origin outside
        s2_next.near = sb.b[WQ1-1] && !sb.cq_neg;
        s2_next.o = sb.o;
        s2_next.d = sb.d;
        s2_next.a = sb.a;
        s2_next.b = sb.b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_reg <= '0;
        end
        else if (en)
        begin
            s2_reg <= s2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qm2_reg <= disc[QMAG_W-1:0];
        end
    end

    // square root of the discriminant with FRAC_BITS extra fraction bits
    logic [WS-1:0] root;
    sb_s_t         ss;

    rsi_sqrt #(.WX(WX)) u_sqrt (
        .clk (clk), .en (en), .x ({qm2_reg, {(2*FRAC_BITS){1'b0}}}), .root (root)
    );
    rsi_dly #(.W($bits(sb_s_t)), .N(WS)) u_dly_s (
        .clk (clk), .rst_n (rst_n), .en (en), .d (s2_reg), .q (ss)
    );

    // stage 3: numerator of t
    sb_c_t                 s3_reg;
    sb_c_t                 s3_next;
    logic signed [WN-1:0]  n3_reg;
    logic signed [WN-1:0]  n3_next;
    logic [2:0][CRD_W-1:0] d3_reg;
    logic signed [WN-1:0]  nb;
    logic signed [WN-1:0]  sq;

    always_comb
    begin
        nb = -(WN'($signed(ss.b)) <<< FRAC_BITS);
        sq = $signed(WN'(root));
        n3_next = ss.near ? nb - sq : nb + sq;
        s3_next.v = ss.v;
        s3_next.hit = ss.hit;
        s3_next.o = ss.o;
        s3_next.a = ss.a;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_reg <= '0;
        end
        else if (en)
        begin
            s3_reg <= s3_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n3_reg <= n3_next;
            d3_reg <= ss.d;
        end
    end

    // phase C: d_i * n per lane
    logic signed [WM-1:0] dn [3];
    sb_c_t                sc;

    for (genvar i = 0; i < 3; i++)
    begin : g_pc
        rsi_mul #(.WA(WN), .WB(CRD_W)) u_dn (
            .clk (clk), .en (en), .a (n3_reg), .b ($signed(d3_reg[i])), .p (dn[i])
        );
    end

    rsi_dly #(.W($bits(sb_c_t)), .N(LC)) u_dly_c (
        .clk (clk), .rst_n (rst_n), .en (en), .d (s3_reg), .q (sc)
    );

    // stage 4: magnitudes, divisor and quotient overflow
    sb_d_t           s4_reg;
    sb_d_t           s4_next;
    logic [WR-1:0]   mag4_reg [3];
    logic [WR-1:0]   mag4_next [3];
    logic [WDEN-1:0] den4_reg;
    logic [WDEN-1:0] den4_next;
    logic [WM-1:0]   mag [3];

    always_comb
    begin
        den4_next = {sc.a, {FRAC_BITS{1'b0}}};
        s4_next.v = sc.v;
        s4_next.hit = sc.hit;
        s4_next.o = sc.o;
        for (int i = 0; i < 3; i++)
        begin
            s4_next.neg[i] = dn[i][WM-1];
            mag[i] = s4_next.neg[i] ? -dn[i] : dn[i];
            s4_next.ovf[i] = mag[i] >= (WM'(den4_next) << QB);
            mag4_next[i] = mag[i][WR-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_reg <= '0;
        end
        else if (en)
        begin
            s4_reg <= s4_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag4_reg <= mag4_next;
            den4_reg <= den4_next;
        end
    end

    // divide per lane
    logic [QB-1:0] quo [3];
    logic          rnz [3];
    sb_d_t         sd;

    for (genvar i = 0; i < 3; i++)
    begin : g_div
        rsi_div #(.WD(WDEN), .QB(QB)) u_div (
            .clk    (clk), .en (en),
            .num    (mag4_reg[i]), .den (den4_reg),
            .quo    (quo[i]), .rem_nz (rnz[i])
        );
    end

    rsi_dly #(.W($bits(sb_d_t)), .N(QB)) u_dly_d (
        .clk (clk), .rst_n (rst_n), .en (en), .d (s4_reg), .q (sd)
    );

    // output stage: floor step, add origin, saturate, zero the point on a miss
    logic signed [QB+1:0]    stp [3];
    logic signed [WO-1:0]    sum [3];
    logic signed [CRD_W-1:0] crd [3];
    point_t                  point_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            stp[i] = $signed({2'b00, quo[i]});
            if (sd.neg[i])
            begin
                stp[i] = -stp[i] - $signed({{(QB+1){1'b0}}, rnz[i]});
            end
            sum[i] = WO'($signed(sd.o[i])) + WO'(stp[i]);
            if (sd.ovf[i])
            begin
                crd[i] = sd.neg[i] ? CRD_MIN : CRD_MAX;
            end
            else if (sum[i] > WO'(CRD_MAX))
            begin
                crd[i] = CRD_MAX;
            end
            else if (sum[i] < WO'(CRD_MIN))
            begin
                crd[i] = CRD_MIN;
            end
            else
            begin
                crd[i] = sum[i][CRD_W-1:0];
            end
            if (!sd.hit)
            begin
                crd[i] = '0;
            end
        end
        point_next.hit = sd.hit;
        point_next.point_x = crd[0];
        point_next.point_y = crd[1];
        point_next.point_z = crd[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            point_reg <= '0;
        end
        else if (en)
        begin
            out_valid_reg <= sd.v;
            point_reg <= point_next;
        end
    end

    assign points.valid = out_valid_reg;
    assign points.data = point_reg;

    a_nohit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        points.valid && !points.data.hit |->
            points.data.point_x == '0 && points.data.point_y == '0 &&
            points.data.point_z == '0)
        else $error("no-hit word carries a nonzero point");

    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> rays.ready)
        else $error("input stalled with an empty output register");

    a_hit_needs_dir: assert property (@(posedge clk) disable iff (!rst_n)
        s2_reg.v && s2_reg.hit |-> s2_reg.a != '0)
        else $error("hit flagged for a zero direction");

    a_out_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(en))
        else $error("output word appeared without a pipeline advance");

endmodule
